>>> src/msdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdh_pkg
// Types and constants shared by the multi-switch debounce and hold block.
// ----------------------------------------------------------------------------
package msdh_pkg;

  // Width of every payload field: one bit per switch for the first four.
  localparam int FIELD_W     = 4;
  localparam int STABLE_W    = 10;
  localparam int HOLD_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [STABLE_W-1:0] STABLE_MAX = {STABLE_W{1'b1}};
  localparam logic [HOLD_W-1:0]   PRESS_MAX  = {HOLD_W{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_STABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MASK  = 2'd2;

  localparam logic [STABLE_W-1:0] MIN_STABLE_RESET = 10'd10;
  localparam logic [HOLD_W-1:0]   HOLD_TICKS_RESET = 16'd800;
  localparam logic [FIELD_W-1:0]  HOLD_MASK_RESET  = 4'd15;

  // What one lane found on the current tick.
  typedef struct packed {
    logic press;
    logic release_ev;
    logic hold;
    logic level;
  } lane_out_t;

  // One result transaction.
  typedef struct packed {
    logic [FIELD_W-1:0] press_events;
    logic [FIELD_W-1:0] release_events;
    logic [FIELD_W-1:0] hold_events;
    logic [FIELD_W-1:0] debounced_levels;
  } result_t;

endpackage
`default_nettype wire

>>> src/msdh_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdh_lane
// Debounce and long-press tracking for one switch, advanced once per tick.
// ----------------------------------------------------------------------------
module msdh_lane (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          advance,
  input  wire                          level_in,
  input  wire                          mask_bit,
  input  wire [msdh_pkg::STABLE_W-1:0] min_stable,
  input  wire [msdh_pkg::HOLD_W-1:0]   hold_ticks,
  output msdh_pkg::lane_out_t          lane_out
);
  import msdh_pkg::*;

  logic                candidate;
  logic [STABLE_W-1:0] stable_count;
  logic                accepted;
  logic [HOLD_W-1:0]   press_count;
  logic                pressed_seen;
  logic                hold_reported;

  logic                candidate_next;
  logic [STABLE_W-1:0] stable_count_next;
  logic                accepted_next;
  logic [HOLD_W-1:0]   press_count_next;
  logic                pressed_seen_next;
  logic                hold_reported_next;
  logic [STABLE_W-1:0] stable_inc;
  logic [HOLD_W-1:0]   press_inc;

  assign stable_inc = (stable_count == STABLE_MAX) ? stable_count : stable_count + 1'b1;
  assign press_inc  = (press_count == PRESS_MAX) ? press_count : press_count + 1'b1;

  always_comb begin
    candidate_next     = candidate;
    stable_count_next  = stable_count;
    accepted_next      = accepted;
    press_count_next   = press_count;
    pressed_seen_next  = pressed_seen;
    hold_reported_next = hold_reported;
    lane_out           = '0;
    if (level_in != candidate) begin
      candidate_next    = level_in;
      stable_count_next = '0;
    end else begin
      stable_count_next = stable_inc;
      if (stable_inc >= min_stable) begin
        if (level_in != accepted) begin
          accepted_next     = level_in;
          press_count_next  = '0;
          pressed_seen_next = 1'b1;
          if (!level_in) begin
            lane_out.press = 1'b1;
          end else begin
            // The release that ends a reported hold stays silent.
            lane_out.release_ev = !hold_reported;
            hold_reported_next  = 1'b0;
          end
        end else if (!level_in && pressed_seen && !hold_reported) begin
          press_count_next = press_inc;
          if (press_inc >= hold_ticks && mask_bit) begin
            lane_out.hold      = 1'b1;
            hold_reported_next = 1'b1;
          end
        end
      end
    end
    lane_out.level = accepted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate     <= 1'b1;
      stable_count  <= '0;
      accepted      <= 1'b1;
      press_count   <= '0;
      pressed_seen  <= 1'b0;
      hold_reported <= 1'b0;
    end else if (advance) begin
      candidate     <= candidate_next;
      stable_count  <= stable_count_next;
      accepted      <= accepted_next;
      press_count   <= press_count_next;
      pressed_seen  <= pressed_seen_next;
      hold_reported <= hold_reported_next;
    end
  end

endmodule
`default_nettype wire

>>> src/msdh_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msdh_merge
// Gathers the lane results into the output fields and buffers them in an
// output register backed by a skid register.
// ----------------------------------------------------------------------------
module msdh_merge #(
  parameter int SWITCH_COUNT = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  msdh_pkg::lane_out_t lanes [SWITCH_COUNT],
  output logic                full,
  output logic                out_valid,
  input  wire                 out_stall,
  output msdh_pkg::result_t   out_data
);
  import msdh_pkg::*;

  result_t merged;
  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  // Only the first four switches reach the fields; missing ones read as zero.
  always_comb begin
    merged = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (i < SWITCH_COUNT) begin
        merged.press_events[i]     = lanes[i].press;
        merged.release_events[i]   = lanes[i].release_ev;
        merged.hold_events[i]      = lanes[i].hold;
        merged.debounced_levels[i] = lanes[i].level;
      end
    end
  end

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= merged;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data <= merged;
      end else begin
        skid_data <= merged;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/multi_switch_debounce_hold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_switch_debounce_hold
// Debounces a group of push switches tick by tick and reports press,
// release and long-press hold events with the debounced levels.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    raw_levels
//   out      out_valid / out_stall  press_events, release_events,
//                                   hold_events, debounced_levels
//   cfg      cfg_write              cfg_index, cfg_data
//
// One tick transaction is taken every cycle unless in_stall is high; its
// result is registered. Each switch lane updates its counters in the cycle
// of acceptance. Reset clears the lane counters, sets each lane released and
// loads the register defaults at once. The output register and a skid
// register absorb a stall; in_stall rises only when both hold results.
// ----------------------------------------------------------------------------
module multi_switch_debounce_hold #(
  parameter int SWITCH_COUNT = 4
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire [msdh_pkg::FIELD_W-1:0]     raw_levels,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [msdh_pkg::FIELD_W-1:0]    press_events,
  output logic [msdh_pkg::FIELD_W-1:0]    release_events,
  output logic [msdh_pkg::FIELD_W-1:0]    hold_events,
  output logic [msdh_pkg::FIELD_W-1:0]    debounced_levels,
  input  wire                             cfg_write,
  input  wire [msdh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [msdh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import msdh_pkg::*;

  logic [STABLE_W-1:0] min_stable_ticks;
  logic [HOLD_W-1:0]   hold_ticks;
  logic [FIELD_W-1:0]  hold_enable_mask;

  logic      accept;
  logic      full;
  lane_out_t lanes [SWITCH_COUNT];
  result_t   result;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_stable_ticks <= MIN_STABLE_RESET;
      hold_ticks       <= HOLD_TICKS_RESET;
      hold_enable_mask <= HOLD_MASK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_STABLE: min_stable_ticks <= cfg_data[STABLE_W-1:0];
        REG_HOLD_TICKS: hold_ticks       <= cfg_data[HOLD_W-1:0];
        REG_HOLD_MASK:  hold_enable_mask <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  for (genvar i = 0; i < SWITCH_COUNT; i++) begin : g_lane
    logic level_in;
    logic mask_bit;
    // Switches past the field width see a pressed level and no hold enable.
    if (i < FIELD_W) begin : g_wired
      assign level_in = raw_levels[i];
      assign mask_bit = hold_enable_mask[i];
    end else begin : g_extra
      assign level_in = 1'b0;
      assign mask_bit = 1'b0;
    end
    msdh_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .advance    (accept),
      .level_in   (level_in),
      .mask_bit   (mask_bit),
      .min_stable (min_stable_ticks),
      .hold_ticks (hold_ticks),
      .lane_out   (lanes[i])
    );
  end

  msdh_merge #(
    .SWITCH_COUNT (SWITCH_COUNT)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .lanes     (lanes),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (result)
  );

  assign press_events     = result.press_events;
  assign release_events   = result.release_events;
  assign hold_events      = result.hold_events;
  assign debounced_levels = result.debounced_levels;

  // The skid register fills only behind a waiting result.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_press_not_release: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (press_events & release_events) == '0)
    else $error("press and release on the same switch");

  a_press_level_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((press_events | hold_events) & debounced_levels) == '0)
    else $error("press or hold reported on an open switch");

  a_release_level_high: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (release_events & ~debounced_levels) == '0)
    else $error("release reported on a pressed switch");

endmodule
`default_nettype wire

>>> dv/multi_switch_debounce_hold_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_switch_debounce_hold_test
// Self-checking testbench for the switch debouncer with long-press hold.
// Every accepted tick is run through a behavioral debouncer kept in the
// testbench. The expected event words are queued and compared field by
// field with each result taken from the output channel. Directed tests hit
// the threshold extremes and the special cases. Random switch episodes
// (bounce, then a stable level) run under several register settings, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module multi_switch_debounce_hold_test;
  import msdh_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [FIELD_W-1:0]     raw_levels = '1;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FIELD_W-1:0]     press_events;
  logic [FIELD_W-1:0]     release_events;
  logic [FIELD_W-1:0]     hold_events;
  logic [FIELD_W-1:0]     debounced_levels;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Register copies and per-switch debounce state of the behavioral model.
  logic [STABLE_W-1:0] cfg_min_stable;
  logic [HOLD_W-1:0]   cfg_hold_ticks;
  logic [FIELD_W-1:0]  cfg_hold_mask;
  logic                cand_lvl     [FIELD_W];
  logic [STABLE_W-1:0] stable_cnt   [FIELD_W];
  logic                deb_lvl      [FIELD_W];
  logic [HOLD_W-1:0]   press_cnt    [FIELD_W];
  logic                press_armed  [FIELD_W];
  logic                hold_flagged [FIELD_W];

  result_t     expected_events [$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  logic        quiet_mode = 1'b0;
  logic        hold_off_req = 1'b0;

  multi_switch_debounce_hold u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_levels      (raw_levels),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .press_events    (press_events),
    .release_events  (release_events),
    .hold_events     (hold_events),
    .debounced_levels(debounced_levels),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // One tick of the debouncer: updates the lane state, returns the events.
  function automatic result_t debounce_tick(input logic [FIELD_W-1:0] levels);
    result_t ev;
    logic    lvl;
    ev = '0;
    for (int i = 0; i < FIELD_W; i++) begin
      lvl = levels[i];
      if (lvl != cand_lvl[i]) begin
        cand_lvl[i]   = lvl;
        stable_cnt[i] = '0;
      end else begin
        if (stable_cnt[i] != STABLE_MAX) stable_cnt[i] = stable_cnt[i] + 1'b1;
        if (stable_cnt[i] >= cfg_min_stable) begin
          if (lvl != deb_lvl[i]) begin
            deb_lvl[i]     = lvl;
            press_cnt[i]   = '0;
            press_armed[i] = 1'b1;
            if (!lvl) begin
              ev.press_events[i] = 1'b1;
            end else begin
              // The release that ends a reported hold stays silent.
              if (!hold_flagged[i]) ev.release_events[i] = 1'b1;
              hold_flagged[i] = 1'b0;
            end
          end else if (!lvl && press_armed[i] && !hold_flagged[i]) begin
            if (press_cnt[i] != PRESS_MAX) press_cnt[i] = press_cnt[i] + 1'b1;
            if (press_cnt[i] >= cfg_hold_ticks && cfg_hold_mask[i]) begin
              ev.hold_events[i] = 1'b1;
              hold_flagged[i]   = 1'b1;
            end
          end
        end
      end
      ev.debounced_levels[i] = deb_lvl[i];
    end
    return ev;
  endfunction

  // Most gaps are zero, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode || roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) expected_events.push_back(debounce_tick(raw_levels));
  end

  task automatic check_field(input string name, input logic [FIELD_W-1:0] exp_val,
                             input logic [FIELD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    result_t exp_ev;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("result transaction with no tick pending");
        fail_count++;
      end else begin
        exp_ev = expected_events.pop_front();
        check_field("press_events", exp_ev.press_events, press_events);
        check_field("release_events", exp_ev.release_events, release_events);
        check_field("hold_events", exp_ev.hold_events, hold_events);
        check_field("debounced_levels", exp_ev.debounced_levels, debounced_levels);
      end
    end
  end

  // Receiver side: random stalls, or one long hold-off when requested.
  always begin : out_stall_driver
    int unsigned span;
    @(posedge clk);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_stall <= 1'b1;
      repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
    end else begin
      span = pick_gap();
      out_stall <= (span != 0);
      if (span > 1) repeat (span - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_tick(input logic [FIELD_W-1:0] levels);
    int unsigned gap;
    in_valid   <= 1'b1;
    raw_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_repeat(input logic [FIELD_W-1:0] levels, input int unsigned n);
    repeat (n) send_tick(levels);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_MIN_STABLE: cfg_min_stable = data[STABLE_W-1:0];
      REG_HOLD_TICKS: cfg_hold_ticks = data[HOLD_W-1:0];
      REG_HOLD_MASK:  cfg_hold_mask  = data[FIELD_W-1:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits are filled with noise; the block must drop them.
  task automatic apply_settings(input logic [STABLE_W-1:0] min_stable,
                                input logic [HOLD_W-1:0] hold_len,
                                input logic [FIELD_W-1:0] mask);
    logic [CFG_DATA_W-1:0] noise;
    wait_drained();
    noise = CFG_DATA_W'($urandom_range(0, 65535));
    write_reg(REG_MIN_STABLE, {noise[CFG_DATA_W-1:STABLE_W], min_stable});
    write_reg(REG_HOLD_TICKS, hold_len);
    noise = CFG_DATA_W'($urandom_range(0, 65535));
    write_reg(REG_HOLD_MASK, {noise[CFG_DATA_W-1:FIELD_W], mask});
    cfg_write <= 1'b0;
  endtask

  // Short thresholds: press, hold on enabled lanes only, then a release that
  // is silent where the hold was reported, then some bounce.
  task automatic test_directed_events();
    logic [FIELD_W-1:0] seq [] = '{4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
                                   4'hF, 4'hF, 4'hF, 4'h5, 4'hA, 4'h5, 4'h5, 4'h5};
    apply_settings(10'd2, 16'd3, 4'b0101);
    foreach (seq[k]) send_tick(seq[k]);
  endtask

  task automatic test_zero_thresholds();
    logic [FIELD_W-1:0] seq [] = '{4'h0, 4'h0, 4'h0, 4'hF, 4'hF,
                                   4'h6, 4'h6, 4'h6, 4'hF, 4'hF};
    apply_settings(10'd0, 16'd0, 4'hF);
    foreach (seq[k]) send_tick(seq[k]);
  endtask

  // A write to the spare index must leave every register alone.
  task automatic test_unused_register();
    wait_drained();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_write <= 1'b0;
    send_repeat(4'h9, 4);
    send_repeat(4'h0, 4);
  endtask

  // Largest debounce time; short stable stretches are never accepted.
  task automatic test_max_stable();
    apply_settings(STABLE_MAX, 16'd5, 4'hF);
    send_repeat(4'hF, 20);
    send_repeat(4'h0, 60);
    send_repeat(4'hA, 20);
  endtask

  // Largest hold time; a press much shorter than it raises no hold.
  task automatic test_max_hold();
    apply_settings(10'd1, PRESS_MAX, 4'b0011);
    quiet_mode = 1'b1;
    send_repeat(4'hF, 4);
    send_repeat(4'h0, 60);
    send_repeat(4'hF, 5);
    quiet_mode = 1'b0;
  endtask

  // The receiver stops for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    quiet_mode   = 1'b1;
    hold_off_req = 1'b1;
    while (hold_off_req) @(posedge clk);
    repeat (40) send_tick(FIELD_W'($urandom_range(0, 15)));
    quiet_mode = 1'b0;
  endtask

  // Mostly bounce followed by a stable level of random length; some noise.
  task automatic run_episodes(input int unsigned n_items);
    int unsigned        sent;
    int unsigned        bounce_n;
    int unsigned        run_len;
    int unsigned        max_len;
    logic [FIELD_W-1:0] target;
    logic [FIELD_W-1:0] flips;
    sent   = 0;
    target = 4'hF;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 20) begin
        send_tick(FIELD_W'($urandom_range(0, 15)));
        sent++;
      end else begin
        flips = FIELD_W'($urandom_range(0, 15));
        // Half the time only a few lanes move, so long presses overlap churn.
        if ($urandom_range(0, 1)) flips = flips & 4'($urandom_range(0, 15));
        target   = target ^ flips;
        bounce_n = $urandom_range(0, 3);
        repeat (bounce_n) send_tick(target ^ 4'($urandom_range(0, 15)));
        max_len = cfg_min_stable + cfg_hold_ticks + 4;
        run_len = $urandom_range(1, max_len);
        send_repeat(target, run_len);
        sent += bounce_n + run_len;
      end
    end
  endtask

  task automatic test_random_sequences();
    for (int s = 0; s < 4; s++) begin
      if (s == 0) apply_settings(10'd1, 16'd1, 4'hF);
      else apply_settings(STABLE_W'($urandom_range(1, 6)), HOLD_W'($urandom_range(2, 20)),
                          FIELD_W'($urandom_range(0, 15)));
      // One setting runs with no idling on either side.
      quiet_mode = (s == 1);
      run_episodes(280);
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    cfg_min_stable = MIN_STABLE_RESET;
    cfg_hold_ticks = HOLD_TICKS_RESET;
    cfg_hold_mask  = HOLD_MASK_RESET;
    for (int i = 0; i < FIELD_W; i++) begin
      cand_lvl[i]     = 1'b1;
      stable_cnt[i]   = '0;
      deb_lvl[i]      = 1'b1;
      press_cnt[i]    = '0;
      press_armed[i]  = 1'b0;
      hold_flagged[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults first: a short press and release.
    send_repeat(4'h0, 14);
    send_repeat(4'hF, 14);
    test_directed_events();
    test_zero_thresholds();
    test_unused_register();
    test_max_stable();
    test_max_hold();
    test_backpressure();
    test_random_sequences();

    wait_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
